>>> src/gos_pkg.sv
// Shared widths, register indexes and word types for the orbit step pipeline.
// No dependencies; imported by gos_div_pipe and gravity_orbit_step_fixed.
`timescale 1ns / 1ps

package gos_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FIELD_W   = 31;
  localparam int GP_W      = 31;
  localparam int CAP_W     = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAV_PARAM  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_RSQ = CFG_IDX_W'(1);

  localparam logic [GP_W-1:0]  GRAV_PARAM_RST  = GP_W'(6062080);
  localparam logic [CAP_W-1:0] CAPTURE_RSQ_RST = CAP_W'(1) << (2 * FRAC_BITS - 12);

  localparam int MAG_W     = FIELD_W;
  localparam int SQR_W     = 2 * MAG_W - FRAC_BITS;  // one square after the shift
  localparam int R2_W      = SQR_W + 1;              // sum of two squares
  localparam int SQ_STEPS  = 32;                     // root digits
  localparam int SQ_IN_W   = 2 * SQ_STEPS;
  localparam int SQ_ROOT_W = SQ_STEPS + 2;
  localparam int SQ_REM_W  = SQ_STEPS + 4;
  localparam int R_W       = SQ_STEPS;
  localparam int ACC_W     = GP_W + FRAC_BITS;
  localparam int QA_W      = 33;                     // acc / r, larger means capped
  localparam int QP_W      = QA_W + MAG_W;
  localparam int RP_W      = R_W + MAG_W;
  localparam int TQ_W      = MAG_W;
  localparam int TERM_W    = 41;
  localparam int SUM_W     = TERM_W + 2;

  localparam logic [TERM_W-1:0] TERM_CAP = TERM_W'(1) << (TERM_W - 1);

  typedef struct packed {
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] vel_x;
    logic signed [FIELD_W-1:0] vel_y;
    logic [MAG_W-1:0]          mag_x;
    logic [MAG_W-1:0]          mag_y;
    logic                      swal;
  } body_t;

  typedef struct packed {
    body_t          body;
    logic [R_W-1:0] r;
  } body_r_t;

  typedef struct packed {
    body_r_t br;
    logic    cap;
  } body_rc_t;

  typedef struct packed {
    logic [QP_W-1:0] pq;
    body_rc_t        rc;
  } term_side_t;

endpackage

>>> src/gos_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on gos_pkg for default widths. Caller keeps num >> QUO_W below den.
`timescale 1ns / 1ps

module gos_div_pipe
  import gos_pkg::*;
#(
  parameter int NUM_W  = ACC_W,
  parameter int DEN_W  = R2_W,
  parameter int QUO_W  = ACC_W,
  parameter int SIDE_W = FIELD_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [QUO_W-1:0]  out_quo,
  output logic [DEN_W-1:0]  out_rem,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld_r   [QUO_W];
  logic [DEN_W-1:0]  rem_r   [QUO_W];
  logic [QUO_W-1:0]  lq_r    [QUO_W];  // dividend bits out the top, quotient in below
  logic [DEN_W-1:0]  den_r   [QUO_W];
  logic [SIDE_W-1:0] side_r  [QUO_W];

  logic              vld_in  [QUO_W];
  logic [DEN_W-1:0]  rem_in  [QUO_W];
  logic [QUO_W-1:0]  lq_in   [QUO_W];
  logic [DEN_W-1:0]  den_in  [QUO_W];
  logic [SIDE_W-1:0] side_in [QUO_W];

  logic [DEN_W:0]    trial   [QUO_W];
  logic [DEN_W:0]    diff    [QUO_W];
  logic              ge      [QUO_W];
  logic [DEN_W-1:0]  rem_nxt [QUO_W];
  logic [QUO_W-1:0]  lq_nxt  [QUO_W];

  logic [NUM_W+DEN_W-1:0] num_ext;

  assign num_ext = {{DEN_W{1'b0}}, in_num};

  always_comb begin
    vld_in[0]  = in_vld;
    rem_in[0]  = num_ext[QUO_W +: DEN_W];
    lq_in[0]   = in_num[QUO_W-1:0];
    den_in[0]  = in_den;
    side_in[0] = in_side;
    for (int k = 1; k < QUO_W; k++) begin
      vld_in[k]  = vld_r[k-1];
      rem_in[k]  = rem_r[k-1];
      lq_in[k]   = lq_r[k-1];
      den_in[k]  = den_r[k-1];
      side_in[k] = side_r[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      trial[k]   = {rem_in[k], lq_in[k][QUO_W-1]};
      diff[k]    = trial[k] - {1'b0, den_in[k]};
      ge[k]      = trial[k] >= {1'b0, den_in[k]};
      rem_nxt[k] = ge[k] ? diff[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
      lq_nxt[k]  = {lq_in[k][QUO_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QUO_W; k++) vld_r[k] <= 1'b0;
    end else begin
      for (int k = 0; k < QUO_W; k++) vld_r[k] <= vld_in[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QUO_W; k++) begin
      rem_r[k]  <= rem_nxt[k];
      lq_r[k]   <= lq_nxt[k];
      den_r[k]  <= den_in[k];
      side_r[k] <= side_in[k];
    end
  end

  assign out_vld  = vld_r[QUO_W-1];
  assign out_quo  = lq_r[QUO_W-1];
  assign out_rem  = rem_r[QUO_W-1];
  assign out_side = side_r[QUO_W-1];

endmodule

>>> src/gravity_orbit_step_fixed.sv
// Top level: one Euler-Cromer orbit step around a central mass, signed 15.16 fixed point.
// Depends on gos_pkg and gos_div_pipe.
`timescale 1ns / 1ps

// Usage
//   Input: pulse start with a body word on in_pos_x/y, in_vel_x/y. busy is
//   always low, so a word is taken on every cycle that start is high.
//   Output: out_valid marks one cycle in which the updated word sits on
//   out_new_*, out_swallowed and out_saturated. The receiver cannot stall;
//   words leave in the order they came in.
//   Throughput: one word per cycle. The pipeline depth comes from the
//   bit-serial units, each one bit per stage: square root (32), GM/r2 (47),
//   acc/r (33) and the per-axis remainder term (31), plus 7 register stages
//   for squares, sums, multiplies and the velocity and position updates.
//   Config: cfg_we writes register cfg_index (0: GM, 1: capture radius
//   squared) at once; write only while no word is in flight.
//   Reset: synchronous, active low; clears the pipeline valid bits and loads
//   the default GM and capture radius. Words in flight are dropped.
//   A swallowed body (r2 zero or under the capture radius squared) leaves unchanged,
//   the remaining arithmetic on it runs but is discarded.
module gravity_orbit_step_fixed
  import gos_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [FIELD_W-1:0] in_pos_x,
  input  logic signed [FIELD_W-1:0] in_pos_y,
  input  logic signed [FIELD_W-1:0] in_vel_x,
  input  logic signed [FIELD_W-1:0] in_vel_y,
  output logic                      out_valid,
  output logic signed [FIELD_W-1:0] out_new_pos_x,
  output logic signed [FIELD_W-1:0] out_new_pos_y,
  output logic signed [FIELD_W-1:0] out_new_vel_x,
  output logic signed [FIELD_W-1:0] out_new_vel_y,
  output logic                      out_swallowed,
  output logic                      out_saturated,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata
);

  localparam logic signed [SUM_W-1:0] FLD_MAX = (SUM_W'(1) <<< (FIELD_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] FLD_MIN = -(SUM_W'(1) <<< (FIELD_W - 1));
  localparam int LAST = SQ_STEPS - 1;

  function automatic logic signed [FIELD_W-1:0] fld_clamp(input logic signed [SUM_W-1:0] v);
    if (v > FLD_MAX) return FLD_MAX[FIELD_W-1:0];
    if (v < FLD_MIN) return FLD_MIN[FIELD_W-1:0];
    return v[FIELD_W-1:0];
  endfunction

  function automatic logic fld_over(input logic signed [SUM_W-1:0] v);
    return (v > FLD_MAX) || (v < FLD_MIN);
  endfunction

  // config registers
  logic [GP_W-1:0]  grav_param_r;
  logic [CAP_W-1:0] capture_rsq_r;

  // front end: magnitudes, squares, r2 and swallow test
  logic              s1_vld_r, s2_vld_r, s3_vld_r;
  body_t             s1_body_r, s2_body_r, s3_body_r;
  body_t             s1_body_nxt, s3_body_nxt;
  logic [SQR_W-1:0]  s2_sqx_r, s2_sqy_r;
  logic [R2_W-1:0]   s3_r2_r;
  logic [2*MAG_W-1:0] prod_x, prod_y;
  logic [R2_W-1:0]   r2_sum;

  // square root, one digit per stage
  logic                 sq_vld_r  [SQ_STEPS];
  logic [SQ_ROOT_W-1:0] sq_root_r [SQ_STEPS];
  logic [SQ_REM_W-1:0]  sq_rem_r  [SQ_STEPS];
  logic [SQ_IN_W-1:0]   sq_v_r    [SQ_STEPS];
  logic [R2_W-1:0]      sq_r2_r   [SQ_STEPS];
  body_t                sq_body_r [SQ_STEPS];
  logic                 sq_vld_in  [SQ_STEPS];
  logic [SQ_ROOT_W-1:0] sq_root_in [SQ_STEPS];
  logic [SQ_REM_W-1:0]  sq_rem_in  [SQ_STEPS];
  logic [SQ_IN_W-1:0]   sq_v_in    [SQ_STEPS];
  logic [R2_W-1:0]      sq_r2_in   [SQ_STEPS];
  body_t                sq_body_in [SQ_STEPS];
  logic [SQ_ROOT_W-1:0] sq_root_s  [SQ_STEPS];
  logic [SQ_REM_W-1:0]  sq_rem_s   [SQ_STEPS];
  logic                 sq_take    [SQ_STEPS];
  logic [SQ_ROOT_W-1:0] sq_root_nxt[SQ_STEPS];
  logic [SQ_REM_W-1:0]  sq_rem_nxt [SQ_STEPS];

  // dividers
  body_r_t          acc_side_in, acc_side;
  logic             acc_vld;
  logic [ACC_W-1:0] acc_quo;
  logic [ACC_W-1:0] acc_hi;
  body_rc_t         qa_side_in, qa_side;
  logic             qa_vld;
  logic [QA_W-1:0]  qa_quo;
  logic [R_W-1:0]   qa_rem;

  // multiplies
  logic             m_vld_r;
  logic [QP_W-1:0]  m_pqx_r, m_pqy_r;
  logic [RP_W-1:0]  m_prx_r, m_pry_r;
  body_rc_t         m_rc_r;

  term_side_t       tx_side_in, tx_side;
  logic             tx_vld;
  logic [TQ_W-1:0]  tx_quo, ty_quo;
  logic [QP_W-1:0]  ty_pq;

  // term, velocity and position stages
  logic [QP_W:0]    sum_x, sum_y;
  logic             t_vld_r;
  logic [TERM_W-1:0] t_dx_r, t_dy_r;
  body_t            t_body_r;
  logic signed [SUM_W-1:0] dxs, dys, nvx, nvy;
  logic             v_vld_r;
  body_t            v_body_r;
  logic signed [FIELD_W-1:0] v_vx_r, v_vy_r;
  logic             v_sat_r;
  logic signed [SUM_W-1:0] npx, npy;

  logic                      out_valid_r;
  logic signed [FIELD_W-1:0] out_pos_x_r, out_pos_y_r, out_vel_x_r, out_vel_y_r;
  logic                      out_swal_r, out_sat_r;

  assign busy = 1'b0;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_param_r  <= GRAV_PARAM_RST;
      capture_rsq_r <= CAPTURE_RSQ_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRAV_PARAM:  grav_param_r  <= cfg_wdata[GP_W-1:0];
        CFG_CAPTURE_RSQ: capture_rsq_r <= cfg_wdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- stage 1: capture and magnitudes ----
  always_comb begin
    s1_body_nxt.pos_x = in_pos_x;
    s1_body_nxt.pos_y = in_pos_y;
    s1_body_nxt.vel_x = in_vel_x;
    s1_body_nxt.vel_y = in_vel_y;
    // -(-2^30) wraps to the bit pattern of +2^30, right as unsigned
    s1_body_nxt.mag_x = in_pos_x[FIELD_W-1] ? unsigned'(-in_pos_x) : unsigned'(in_pos_x);
    s1_body_nxt.mag_y = in_pos_y[FIELD_W-1] ? unsigned'(-in_pos_y) : unsigned'(in_pos_y);
    s1_body_nxt.swal  = 1'b0;
  end

  // ---- stage 2: squares ----
  assign prod_x = s1_body_r.mag_x * s1_body_r.mag_x;
  assign prod_y = s1_body_r.mag_y * s1_body_r.mag_y;

  // ---- stage 3: r2 and capture test ----
  assign r2_sum = {1'b0, s2_sqx_r} + {1'b0, s2_sqy_r};

  always_comb begin
    s3_body_nxt      = s2_body_r;
    // zero distance always counts as swallowed
    s3_body_nxt.swal = (r2_sum == '0) ||
                       (r2_sum < {{(R2_W-CAP_W){1'b0}}, capture_rsq_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_body_r <= s1_body_nxt;
    s2_body_r <= s1_body_r;
    s2_sqx_r  <= prod_x[2*MAG_W-1:FRAC_BITS];
    s2_sqy_r  <= prod_y[2*MAG_W-1:FRAC_BITS];
    s3_body_r <= s3_body_nxt;
    s3_r2_r   <= r2_sum;
  end

  // ---- square root of r2 << FRAC_BITS, two input bits per stage ----
  always_comb begin
    sq_vld_in[0]  = s3_vld_r;
    sq_root_in[0] = '0;
    sq_rem_in[0]  = '0;
    sq_v_in[0]    = {{(SQ_IN_W-R2_W-FRAC_BITS){1'b0}}, s3_r2_r, {FRAC_BITS{1'b0}}};
    sq_r2_in[0]   = s3_r2_r;
    sq_body_in[0] = s3_body_r;
    for (int k = 1; k < SQ_STEPS; k++) begin
      sq_vld_in[k]  = sq_vld_r[k-1];
      sq_root_in[k] = sq_root_r[k-1];
      sq_rem_in[k]  = sq_rem_r[k-1];
      sq_v_in[k]    = sq_v_r[k-1];
      sq_r2_in[k]   = sq_r2_r[k-1];
      sq_body_in[k] = sq_body_r[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      sq_root_s[k]   = {sq_root_in[k][SQ_ROOT_W-2:0], 1'b0};
      sq_rem_s[k]    = {sq_rem_in[k][SQ_REM_W-3:0], sq_v_in[k][SQ_IN_W-1 -: 2]};
      sq_take[k]     = SQ_REM_W'(sq_root_s[k]) < sq_rem_s[k];
      sq_root_nxt[k] = sq_take[k] ? sq_root_s[k] + SQ_ROOT_W'(2) : sq_root_s[k];
      sq_rem_nxt[k]  = sq_take[k] ? sq_rem_s[k] - SQ_REM_W'(sq_root_s[k]) - SQ_REM_W'(1)
                                  : sq_rem_s[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQ_STEPS; k++) sq_vld_r[k] <= 1'b0;
    end else begin
      for (int k = 0; k < SQ_STEPS; k++) sq_vld_r[k] <= sq_vld_in[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      sq_root_r[k] <= sq_root_nxt[k];
      sq_rem_r[k]  <= sq_rem_nxt[k];
      sq_v_r[k]    <= {sq_v_in[k][SQ_IN_W-3:0], 2'b00};
      sq_r2_r[k]   <= sq_r2_in[k];
      sq_body_r[k] <= sq_body_in[k];
    end
  end

  // ---- acc = (GM << FRAC_BITS) / r2 ----
  assign acc_side_in.body = sq_body_r[LAST];
  assign acc_side_in.r    = sq_root_r[LAST][R_W:1];

  gos_div_pipe #(
    .NUM_W (ACC_W),
    .DEN_W (R2_W),
    .QUO_W (ACC_W),
    .SIDE_W($bits(body_r_t))
  ) u_div_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (sq_vld_r[LAST]),
    .in_num  ({grav_param_r, {FRAC_BITS{1'b0}}}),
    .in_den  (sq_r2_r[LAST]),
    .in_side (acc_side_in),
    .out_vld (acc_vld),
    .out_quo (acc_quo),
    .out_rem (),
    .out_side(acc_side)
  );

  // ---- qa, ra = acc / r; a quotient past QA_W bits caps the term ----
  assign acc_hi         = acc_quo >> QA_W;
  assign qa_side_in.br  = acc_side;
  assign qa_side_in.cap = acc_hi >= ACC_W'(acc_side.r);

  gos_div_pipe #(
    .NUM_W (ACC_W),
    .DEN_W (R_W),
    .QUO_W (QA_W),
    .SIDE_W($bits(body_rc_t))
  ) u_div_qa (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (acc_vld),
    .in_num  (acc_quo),
    .in_den  (acc_side.r),
    .in_side (qa_side_in),
    .out_vld (qa_vld),
    .out_quo (qa_quo),
    .out_rem (qa_rem),
    .out_side(qa_side)
  );

  // ---- qa*m and ra*m per axis ----
  always_ff @(posedge clk) begin
    if (!rst_n) m_vld_r <= 1'b0;
    else        m_vld_r <= qa_vld;
  end

  always_ff @(posedge clk) begin
    m_pqx_r <= qa_quo * qa_side.br.body.mag_x;
    m_pqy_r <= qa_quo * qa_side.br.body.mag_y;
    m_prx_r <= qa_rem * qa_side.br.body.mag_x;
    m_pry_r <= qa_rem * qa_side.br.body.mag_y;
    m_rc_r  <= qa_side;
  end

  // ---- (ra*m) / r per axis; quotient stays below m ----
  assign tx_side_in.pq = m_pqx_r;
  assign tx_side_in.rc = m_rc_r;

  gos_div_pipe #(
    .NUM_W (RP_W),
    .DEN_W (R_W),
    .QUO_W (TQ_W),
    .SIDE_W($bits(term_side_t))
  ) u_div_tx (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (m_vld_r),
    .in_num  (m_prx_r),
    .in_den  (m_rc_r.br.r),
    .in_side (tx_side_in),
    .out_vld (tx_vld),
    .out_quo (tx_quo),
    .out_rem (),
    .out_side(tx_side)
  );

  gos_div_pipe #(
    .NUM_W (RP_W),
    .DEN_W (R_W),
    .QUO_W (TQ_W),
    .SIDE_W(QP_W)
  ) u_div_ty (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (m_vld_r),
    .in_num  (m_pry_r),
    .in_den  (m_rc_r.br.r),
    .in_side (m_pqy_r),
    .out_vld (),
    .out_quo (ty_quo),
    .out_rem (),
    .out_side(ty_pq)
  );

  // ---- term = qa*m + (ra*m)/r, capped; a zero axis has no pull ----
  assign sum_x = {1'b0, tx_side.pq} + (QP_W+1)'(tx_quo);
  assign sum_y = {1'b0, ty_pq} + (QP_W+1)'(ty_quo);

  always_ff @(posedge clk) begin
    if (!rst_n) t_vld_r <= 1'b0;
    else        t_vld_r <= tx_vld;
  end

  always_ff @(posedge clk) begin
    t_dx_r   <= ((tx_side.rc.cap && tx_side.rc.br.body.mag_x != '0) ||
                 sum_x > (QP_W+1)'(TERM_CAP)) ? TERM_CAP : sum_x[TERM_W-1:0];
    t_dy_r   <= ((tx_side.rc.cap && tx_side.rc.br.body.mag_y != '0) ||
                 sum_y > (QP_W+1)'(TERM_CAP)) ? TERM_CAP : sum_y[TERM_W-1:0];
    t_body_r <= tx_side.rc.br.body;
  end

  // ---- velocity update: term takes the sign of the position ----
  assign dxs = t_body_r.pos_x[FIELD_W-1] ? -$signed({2'b00, t_dx_r}) : $signed({2'b00, t_dx_r});
  assign dys = t_body_r.pos_y[FIELD_W-1] ? -$signed({2'b00, t_dy_r}) : $signed({2'b00, t_dy_r});
  assign nvx = SUM_W'(t_body_r.vel_x) - dxs;
  assign nvy = SUM_W'(t_body_r.vel_y) - dys;

  always_ff @(posedge clk) begin
    if (!rst_n) v_vld_r <= 1'b0;
    else        v_vld_r <= t_vld_r;
  end

  always_ff @(posedge clk) begin
    v_body_r <= t_body_r;
    v_vx_r   <= fld_clamp(nvx);
    v_vy_r   <= fld_clamp(nvy);
    v_sat_r  <= fld_over(nvx) || fld_over(nvy);
  end

  // ---- position update with the clamped velocity, output word ----
  assign npx = SUM_W'(v_body_r.pos_x) + SUM_W'(v_vx_r);
  assign npy = SUM_W'(v_body_r.pos_y) + SUM_W'(v_vy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= v_vld_r;
  end

  always_ff @(posedge clk) begin
    out_swal_r <= v_body_r.swal;
    if (v_body_r.swal) begin
      out_pos_x_r <= v_body_r.pos_x;
      out_pos_y_r <= v_body_r.pos_y;
      out_vel_x_r <= v_body_r.vel_x;
      out_vel_y_r <= v_body_r.vel_y;
      out_sat_r   <= 1'b0;
    end else begin
      out_pos_x_r <= fld_clamp(npx);
      out_pos_y_r <= fld_clamp(npy);
      out_vel_x_r <= v_vx_r;
      out_vel_y_r <= v_vy_r;
      out_sat_r   <= v_sat_r || fld_over(npx) || fld_over(npy);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_pos_x = out_pos_x_r;
  assign out_new_pos_y = out_pos_y_r;
  assign out_new_vel_x = out_vel_x_r;
  assign out_new_vel_y = out_vel_y_r;
  assign out_swallowed = out_swal_r;
  assign out_saturated = out_sat_r;

endmodule
